### design/periodic_task_slot_scheduler_unit_assert.svh
// assertion macros shared by the scheduler rtl
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PTS_ASSERT(label, clk, rst, prop, msg)
`define PTS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### design/pts_pkg.sv
`default_nettype none

package pts_pkg;

  // fixed field widths of the channels
  localparam int SLOT_FIELD_W  = 3;
  localparam int VALUE_FIELD_W = 24;

  // results reported per tick at most
  localparam int MAX_RESULTS = 8;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  // command codes
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_REGISTER = 1'b1;

  typedef struct packed {
    logic used;
    logic active;
  } slot_flags_t;

endpackage

`default_nettype wire

### design/pts_req_if.sv
`default_nettype none

interface pts_req_if
  import pts_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [SLOT_FIELD_W-1:0]  slot;
  logic                     has_action;
  logic [VALUE_FIELD_W-1:0] delay_ticks;
  logic [VALUE_FIELD_W-1:0] period_ticks;

  modport source (
    output valid, command, slot, has_action, delay_ticks, period_ticks,
    input  ready
  );

  modport sink (
    input  valid, command, slot, has_action, delay_ticks, period_ticks,
    output ready
  );
endinterface

`default_nettype wire

### design/pts_fire_if.sv
`default_nettype none

interface pts_fire_if
  import pts_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [SLOT_FIELD_W-1:0] fired_slot;
  logic                    last_fired;

  modport source (
    output valid, fired_slot, last_fired,
    input  ready
  );

  modport sink (
    input  valid, fired_slot, last_fired,
    output ready
  );
endinterface

`default_nettype wire

### design/periodic_task_slot_scheduler_unit.sv
// periodic task slot scheduler
// request channel: command 1 registers a task into a slot (overwriting it),
// command 0 is one scheduler tick. fire channel: one transaction per slot
// that falls due on a tick (at most MAX_RESULTS), in ascending slot order,
// last_fired on the final one; a tick with nothing due gives no transaction.
// a register transaction is written into the slot memory as it is taken. a
// tick walks the slot table with one shared count/reload unit, one slot per
// cycle while the walk is not stalled, over a single-port read / single-port
// write slot memory; request.ready stays low from a tick until its walk and
// flush are done, so a new request is taken only after the tick has finished,
// and the last result of a tick leaves from the flush state. results leave
// through an output register; the walk pauses when a new due slot must push
// the held-back result into that full, untaken register; nothing is lost.
// reset clears the used and action marks of every slot, so no slot counts
// or fires until registered; the slot memory itself needs no clearing.
`default_nettype none
`include "periodic_task_slot_scheduler_unit_assert.svh"

module periodic_task_slot_scheduler_unit
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = 8,
  parameter int COUNT_BITS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  pts_req_if.sink   request,
  pts_fire_if.source fire
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DATA_W = 2 * COUNT_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t                  state;
  logic [SLOT_COUNT-1:0]   slot_used;
  logic [SLOT_COUNT-1:0]   slot_active;
  logic [IDX_W:0]          rd_idx;
  logic                    ex_valid;
  logic [IDX_W-1:0]        ex_idx;
  logic                    pend_valid;
  logic [SLOT_FIELD_W-1:0] pend_slot;
  logic [REP_W-1:0]        rep_cnt;
  logic                    out_valid;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic                    out_last;

  logic                    req_acc;
  logic                    slot_ok;
  logic                    reg_wr;
  logic                    out_free;
  logic                    out_load;
  logic                    rd_done;
  logic                    report;
  logic                    stall;
  logic                    step_fire;
  slot_flags_t             step_flags;
  logic [COUNT_BITS-1:0]   step_next;
  logic [COUNT_BITS-1:0]   cur_count;
  logic [COUNT_BITS-1:0]   cur_period;
  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_wr_addr;
  logic [DATA_W-1:0]       ram_wr_data;
  logic                    ram_rd_en;
  logic [DATA_W-1:0]       ram_rd_data;
  logic [IDX_W-1:0]        reg_idx;

  assign request.ready   = (state == S_IDLE);
  assign fire.valid      = out_valid;
  assign fire.fired_slot = out_slot;
  assign fire.last_fired = out_last;

  assign req_acc  = request.valid && request.ready;
  assign slot_ok  = (32'(request.slot) < 32'(SLOT_COUNT));
  assign reg_wr   = req_acc && (request.command == CMD_REGISTER) && slot_ok;
  assign reg_idx  = IDX_W'(request.slot);
  assign out_free = !out_valid || fire.ready;
  assign rd_done  = (rd_idx == (IDX_W + 1)'(SLOT_COUNT));

  assign cur_count  = ram_rd_data[DATA_W-1:COUNT_BITS];
  assign cur_period = ram_rd_data[COUNT_BITS-1:0];
  assign step_flags = '{used: slot_used[ex_idx], active: slot_active[ex_idx]};

  pts_slot_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .flags     (step_flags),
    .count     (cur_count),
    .period    (cur_period),
    .fire      (step_fire),
    .next_count(step_next)
  );

  // a new due slot pushes the one held back out, so it needs the output free
  assign report = ex_valid && step_fire && (rep_cnt < REP_W'(MAX_RESULTS));
  assign stall  = report && pend_valid && !out_free;

  assign out_load = ((state == S_WALK) && !stall && report && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && out_free);

  always_comb begin
    if (state == S_WALK) begin
      ram_wr_en   = ex_valid && !stall;
      ram_wr_addr = ex_idx;
      ram_wr_data = {step_next, cur_period};
    end else begin
      ram_wr_en   = reg_wr;
      ram_wr_addr = reg_idx;
      ram_wr_data = {COUNT_BITS'(request.delay_ticks), COUNT_BITS'(request.period_ticks)};
    end
  end

  assign ram_rd_en = (state == S_WALK) && !stall && !rd_done;

  pts_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .ADDR_W(IDX_W),
    .DATA_W(DATA_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(rd_idx[IDX_W-1:0]),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_used   <= '0;
      slot_active <= '0;
      rd_idx      <= '0;
      ex_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      rep_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (fire.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (reg_wr) begin
            slot_used[reg_idx]   <= 1'b1;
            slot_active[reg_idx] <= request.has_action;
          end else if (req_acc && (request.command == CMD_TICK)) begin
            state      <= S_WALK;
            rd_idx     <= '0;
            ex_valid   <= 1'b0;
            pend_valid <= 1'b0;
            rep_cnt    <= '0;
          end
        end
        S_WALK: begin
          if (!stall) begin
            if (report) begin
              pend_valid <= 1'b1;
              pend_slot  <= SLOT_FIELD_W'(ex_idx);
              rep_cnt    <= rep_cnt + REP_W'(1);
              if (pend_valid) begin
                out_slot <= pend_slot;
                out_last <= 1'b0;
              end
            end
            if (rd_done) begin
              ex_valid <= 1'b0;
              state    <= S_FLUSH;
            end else begin
              ex_valid <= 1'b1;
              ex_idx   <= rd_idx[IDX_W-1:0];
              rd_idx   <= rd_idx + (IDX_W + 1)'(1);
            end
          end
        end
        S_FLUSH: begin
          // held-back result is the final one of the tick
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_slot   <= pend_slot;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PTS_ASSERT_NEVER(a_rep_cap, clk, rst, rep_cnt > REP_W'(MAX_RESULTS), "too many results in one tick")
  `PTS_ASSERT(a_ex_in_walk, clk, rst, ex_valid |-> state == S_WALK, "slot in flight outside walk")
  `PTS_ASSERT(a_flush_empty, clk, rst, (state == S_FLUSH && !pend_valid) |=> state == S_IDLE, "empty flush did not finish")
  `PTS_ASSERT_NEVER(a_ram_clash, clk, rst, ram_wr_en && ram_rd_en && ram_wr_addr == rd_idx[IDX_W-1:0], "slot read and written together")

endmodule

`default_nettype wire

### design/pts_slot_ram.sv
`default_nettype none

module pts_slot_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/pts_slot_step.sv
`default_nettype none

module pts_slot_step
  import pts_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire slot_flags_t            flags,
  input  wire logic [COUNT_BITS-1:0]  count,
  input  wire logic [COUNT_BITS-1:0]  period,
  output logic                        fire,
  output logic      [COUNT_BITS-1:0]  next_count
);

  logic [COUNT_BITS-1:0] base;

  always_comb begin
    fire = flags.used && flags.active && (count == '0);
    // zero period reloads as one
    if (fire) begin
      base = (period == '0) ? COUNT_BITS'(1) : period;
    end else begin
      base = count;
    end
    if (!flags.used) begin
      next_count = count;
    end else if (base != '0) begin
      next_count = base - COUNT_BITS'(1);
    end else begin
      next_count = '0;
    end
  end

endmodule

`default_nettype wire
